[src/n2w_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_pkg: shared types and constants for the number to word token unit
// token codes, slot layout of one classified request, queue entry type
// ----------------------------------------------------------------------------
package n2w_pkg;

	localparam int VALUE_W    = 31;
	localparam int CODE_W     = 5;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = NUM_DIGITS * 4;
	localparam int NUM_SLOTS  = 16;
	localparam int SLOT_IDX_W = 4;

	// double dabble: 32 bits processed four per cycle
	localparam int DD_BITS      = 32;
	localparam int DD_PER_CYCLE = 4;
	localparam int DD_CYCLES    = DD_BITS / DD_PER_CYCLE;
	localparam int DD_CNT_W     = 3;

	// word token codes
	localparam logic [CODE_W-1:0] TOK_ZERO      = 5'd0;
	localparam logic [CODE_W-1:0] TOK_TEEN_BASE = 5'd10;
	localparam logic [CODE_W-1:0] TOK_TENS_BASE = 5'd18;
	localparam logic [CODE_W-1:0] TOK_HUNDRED   = 5'd28;
	localparam logic [CODE_W-1:0] TOK_THOUSAND  = 5'd29;
	localparam logic [CODE_W-1:0] TOK_MILLION   = 5'd30;
	localparam logic [CODE_W-1:0] TOK_BILLION   = 5'd31;

	// slot layout of one request, in reading order
	localparam int SLOT_BILLION   = 0;
	localparam int SLOT_MILLIONS  = 2;
	localparam int SLOT_THOUSANDS = 7;
	localparam int SLOT_UNITS     = 12;

	typedef struct packed {
		logic [NUM_SLOTS-1:0]             mask;
		logic [NUM_SLOTS-1:0][CODE_W-1:0] code;
	} n2w_entry_t;

endpackage

[src/number_to_word_tokens_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_unit: english word tokens for a 31-bit integer
//
// a request on the value channel (value_valid, value_stall, value) carries one
// unsigned integer; the word channel (word_valid, word_stall, word_code, last)
// returns its english words in reading order, one token per transfer, with
// last set on the final token of each integer. zero gives the single token
// zero; any other value gives 1 to 16 tokens.
// on its way to the first token a value passes through double dabble (4 bits
// a cycle), classification into the queue, and the output register.
// the converter takes a new value once the previous one is converted and
// handed to the queue; the emitter sends one token a cycle while the word
// channel is not stalled, back to back across requests.
// a stalled word channel holds its token; the two-entry queue lets the
// converter keep working until it fills, then value_stall rises.
// reset clears the converter, queue and output valid; nothing else is held.
// ----------------------------------------------------------------------------
module number_to_word_tokens_unit import n2w_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               word_valid,
	input  logic               word_stall,
	output logic [CODE_W-1:0]  word_code,
	output logic               last
);

	// front to queue
	logic       push;
	n2w_entry_t push_entry;
	logic       q_full;

	// queue to back
	logic       head_valid;
	n2w_entry_t head_entry;
	logic       pop;

	// intake, binary to decimal conversion, slot classification
	n2w_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	// decouples conversion from token output
	n2w_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	// one token per cycle, unless the word channel stalls, from the head request into the output register
	n2w_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_code  (word_code),
		.last       (last)
	);

endmodule

[src/n2w_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_front: request intake and classification
// binary to decimal conversion by double dabble, then slot mask and codes
// ----------------------------------------------------------------------------
module n2w_front import n2w_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               value_valid,
	output logic               value_stall,
	input  logic [VALUE_W-1:0] value,
	output logic               push,
	output n2w_entry_t         push_entry,
	input  logic               q_full
);

	typedef struct packed {
		logic [4:0]             mask;
		logic [4:0][CODE_W-1:0] code;
	} grp_t;

	logic                busy_q;
	logic                done_q;
	logic [DD_CNT_W-1:0] cnt_q;
	logic [DD_BITS-1:0]  bin_q;
	logic [BCD_W-1:0]    bcd_q;
	logic [BCD_W-1:0]    bcd_next;
	logic                accept;
	grp_t                grp_m;
	grp_t                grp_t_;
	grp_t                grp_u;

	function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] d);
		logic [BCD_W-1:0] r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (r[i*4 +: 4] >= 4'd5)
				r[i*4 +: 4] = r[i*4 +: 4] + 4'd3;
		end
		return r;
	endfunction

	// words of one three-digit group: hundreds digit, hundred, tens or teen,
	// units, scale
	function automatic grp_t group_slots(input logic [3:0] h, input logic [3:0] t,
			input logic [3:0] u, input logic [CODE_W-1:0] scale);
		grp_t g;
		logic nz;
		nz = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
		g.code[0] = {1'b0, h};
		g.mask[0] = (h != 4'd0);
		g.code[1] = TOK_HUNDRED;
		g.mask[1] = (h != 4'd0);
		if (t == 4'd1) begin
			g.code[2] = TOK_TEEN_BASE + {1'b0, u};
			g.mask[2] = 1'b1;
		end else begin
			g.code[2] = TOK_TENS_BASE + {1'b0, t};
			g.mask[2] = (t != 4'd0);
		end
		g.code[3] = {1'b0, u};
		g.mask[3] = (t != 4'd1) && (u != 4'd0);
		g.code[4] = scale;
		g.mask[4] = nz;
		return g;
	endfunction

	assign value_stall = busy_q || (done_q && q_full);
	assign accept      = value_valid && !value_stall;
	assign push        = done_q && !q_full;

	// four dabble steps per cycle, msb first
	always_comb begin
		bcd_next = bcd_q;
		for (int j = 0; j < DD_PER_CYCLE; j++) begin
			bcd_next = dd_adjust(bcd_next);
			bcd_next = {bcd_next[BCD_W-2:0], bin_q[DD_BITS-1-j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DD_CNT_W'(DD_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (push) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= {1'b0, value};
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[DD_BITS-DD_PER_CYCLE-1:0], {DD_PER_CYCLE{1'b0}}};
			bcd_q <= bcd_next;
		end
	end

	// classify the finished digits into word slots
	always_comb begin
		grp_m  = group_slots(bcd_q[35:32], bcd_q[31:28], bcd_q[27:24], TOK_MILLION);
		grp_t_ = group_slots(bcd_q[23:20], bcd_q[19:16], bcd_q[15:12], TOK_THOUSAND);
		grp_u  = group_slots(bcd_q[11:8], bcd_q[7:4], bcd_q[3:0], TOK_ZERO);

		push_entry = '0;
		push_entry.code[SLOT_BILLION]     = {1'b0, bcd_q[39:36]};
		push_entry.mask[SLOT_BILLION]     = (bcd_q[39:36] != 4'd0);
		push_entry.code[SLOT_BILLION + 1] = TOK_BILLION;
		push_entry.mask[SLOT_BILLION + 1] = (bcd_q[39:36] != 4'd0);
		for (int i = 0; i < 5; i++) begin
			push_entry.code[SLOT_MILLIONS + i]  = grp_m.code[i];
			push_entry.mask[SLOT_MILLIONS + i]  = grp_m.mask[i];
			push_entry.code[SLOT_THOUSANDS + i] = grp_t_.code[i];
			push_entry.mask[SLOT_THOUSANDS + i] = grp_t_.mask[i];
		end
		for (int i = 0; i < 4; i++) begin
			push_entry.code[SLOT_UNITS + i] = grp_u.code[i];
			push_entry.mask[SLOT_UNITS + i] = grp_u.mask[i];
		end
		// zero names itself
		if (bcd_q == '0) begin
			push_entry.code[0] = TOK_ZERO;
			push_entry.mask[0] = 1'b1;
		end
	end

endmodule

[src/n2w_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_queue: two-entry queue between front and back
// holds classified requests so each side stalls on its own
// ----------------------------------------------------------------------------
module n2w_queue import n2w_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  n2w_entry_t push_entry,
	output logic       full,
	output logic       head_valid,
	output n2w_entry_t head_entry,
	input  logic       pop
);

	n2w_entry_t  entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_entry;
	end

endmodule

[src/n2w_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_back: token emitter
// walks the set slots of the head request; when the word channel is not stalled, one token per cycle
// ----------------------------------------------------------------------------
module n2w_back import n2w_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  n2w_entry_t        head_entry,
	output logic              pop,
	output logic              word_valid,
	input  logic              word_stall,
	output logic [CODE_W-1:0] word_code,
	output logic              last
);

	logic                  loaded_q;
	logic [NUM_SLOTS-1:0]  rem_q;
	logic                  word_valid_q;
	logic [CODE_W-1:0]     word_code_q;
	logic                  last_q;
	logic [NUM_SLOTS-1:0]  cur_mask;
	logic [NUM_SLOTS-1:0]  pick;
	logic [NUM_SLOTS-1:0]  rem_next;
	logic [SLOT_IDX_W-1:0] sel;
	logic                  adv;
	logic                  emit;

	assign adv      = !word_valid_q || !word_stall;
	assign emit     = head_valid && adv;
	assign cur_mask = loaded_q ? rem_q : head_entry.mask;
	assign pick     = cur_mask & (~cur_mask + 1'b1);
	assign rem_next = cur_mask & ~pick;
	assign pop      = emit && (rem_next == '0);

	always_comb begin
		sel = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (cur_mask[i])
				sel = SLOT_IDX_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= 1'b0;
			word_valid_q <= 1'b0;
		end else begin
			if (adv)
				word_valid_q <= head_valid;
			if (emit)
				loaded_q <= (rem_next != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rem_q       <= rem_next;
			word_code_q <= head_entry.code[sel];
			last_q      <= (rem_next == '0);
		end
	end

	assign word_valid = word_valid_q;
	assign word_code  = word_code_q;
	assign last       = last_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for number_to_word_tokens_unit
//
// drives integers into the value channel and checks every word token that
// comes back against a behavioral speller kept in this bench. each accepted
// request pushes its expected tokens, last flag included, onto a queue. each
// accepted token is compared with the oldest entry. the run has four parts:
// hand-picked values, a back-to-back burst of long spellings with no idling,
// two bursts that each stop until all words are out, and a long random section.
// ----------------------------------------------------------------------------
module testbench;
	import n2w_pkg::*;

	localparam int  HALF_PERIOD  = 6;
	localparam int  RESET_CYCLES = 4;
	localparam int  IDLE_PCT     = 9;
	localparam int  WATCHDOG_MAX = 2000;
	localparam int  SETTLE       = 16;
	localparam int  NUM_RANDOM   = 280;
	localparam int  NUM_STEADY   = 60;
	localparam int  NUM_BURST    = 10;
	localparam longint VALUE_MAX = 64'd2147483647;

	// one expected word token
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              last;
	} word_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               value_valid = 1'b0;
	logic               value_stall;
	logic [VALUE_W-1:0] value       = '0;
	logic               word_valid;
	logic               word_stall  = 1'b0;
	logic [CODE_W-1:0]  word_code;
	logic               last;

	word_t expected_words[$];
	word_t oldest_word;
	bit    steady_mode   = 1'b0;   // no idling on either side while set
	int    requests_sent = 0;
	int    words_checked = 0;
	int    error_count   = 0;
	int    longest_spell = 0;
	int    quiet_cycles  = 0;

	number_to_word_tokens_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.word_valid  (word_valid),
		.word_stall  (word_stall),
		.word_code   (word_code),
		.last        (last)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// speller: splits the integer into billions, millions, thousands and
	// units groups and queues the words each nonzero group gives
	// ------------------------------------------------------------------------
	function automatic void spell_value(input logic [VALUE_W-1:0] v);
		logic [CODE_W-1:0] toks [0:15];
		logic [CODE_W-1:0] scale_words [0:2];
		int unsigned       groups [0:3];
		int unsigned       num;
		int unsigned       grp;
		int unsigned       hund;
		int unsigned       rest;
		int                n;
		word_t             w;
		num            = v;
		n              = 0;
		groups[0]      = num / 1000000000;
		groups[1]      = (num / 1000000) % 1000;
		groups[2]      = (num / 1000) % 1000;
		groups[3]      = num % 1000;
		scale_words[0] = TOK_BILLION;
		scale_words[1] = TOK_MILLION;
		scale_words[2] = TOK_THOUSAND;
		if (num == 0) begin
			// zero is the only value that says zero
			toks[0] = TOK_ZERO;
			n       = 1;
		end else begin
			for (int i = 0; i < 4; i++) begin
				grp = groups[i];
				if (grp != 0) begin
					hund = grp / 100;
					rest = grp % 100;
					if (hund != 0) begin
						toks[n]     = CODE_W'(hund);
						toks[n + 1] = TOK_HUNDRED;
						n += 2;
					end
					if (rest >= 10 && rest < 20) begin
						// teens are a single word, code equals the number
						toks[n] = CODE_W'(rest);
						n++;
					end else begin
						if (rest / 10 != 0) begin
							toks[n] = TOK_TENS_BASE + CODE_W'(rest / 10);
							n++;
						end
						if (rest % 10 != 0) begin
							toks[n] = CODE_W'(rest % 10);
							n++;
						end
					end
					// units group carries no scale word
					if (i < 3) begin
						toks[n] = scale_words[i];
						n++;
					end
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			w.code = toks[k];
			w.last = (k == n - 1);
			expected_words.push_back(w);
		end
		if (n > longest_spell)
			longest_spell = n;
	endfunction

	// builds an integer from its four three-digit groups, folded into range
	function automatic logic [VALUE_W-1:0] join_groups(input int unsigned b, input int unsigned m,
		input int unsigned t, input int unsigned u);
		longint full;
		full = longint'(b) * 1000000000 + longint'(m) * 1000000 + longint'(t) * 1000 + u;
		while (full > VALUE_MAX)
			full -= 1000000000;
		return VALUE_W'(full);
	endfunction

	// a group that is zero a third of the time, else any 0..999
	function automatic int unsigned sparse_group();
		return ($urandom_range(2) == 0) ? 0 : $urandom_range(999);
	endfunction

	// a group whose words are as many as a group can give: x hundred tens units
	function automatic int unsigned full_group();
		return $urandom_range(1, 9) * 100 + $urandom_range(2, 9) * 10 + $urandom_range(1, 9);
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(5))
			0: v = VALUE_W'($urandom);
			1: v = VALUE_W'($urandom_range(999));
			2: v = join_groups($urandom_range(2), sparse_group(), sparse_group(), sparse_group());
			// teen-heavy groups
			3: v = join_groups($urandom_range(2), $urandom_range(9) * 100 + $urandom_range(10, 19),
				$urandom_range(9) * 100 + $urandom_range(10, 19),
				$urandom_range(9) * 100 + $urandom_range(10, 19));
			// close to the top of the range
			4: v = VALUE_W'(VALUE_MAX - $urandom_range(5000));
			default: v = VALUE_W'($urandom_range(1000000));
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// request driver: called at a falling edge, returns at a falling edge
	// with valid still high, so requests sent back to back in steady mode never drop valid
	// ------------------------------------------------------------------------
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
			value_valid <= 1'b0;
			value       <= VALUE_W'($urandom);
			@(negedge clk);
		end
		value_valid <= 1'b1;
		value       <= v;
		@(posedge clk);
		while (value_stall)
			@(posedge clk);
		// request taken at this edge
		spell_value(v);
		requests_sent++;
		@(negedge clk);
	endtask

	// drop valid and hold off until every queued word has been seen
	task automatic drain_words();
		value_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// word side: random stall at the falling edge, check at the rising edge
	// ------------------------------------------------------------------------
	always @(negedge clk)
		word_stall <= !steady_mode && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && word_valid && !word_stall) begin
			words_checked++;
			if (expected_words.size() == 0) begin
				$display("%0t: token with no request pending: expected none, got code %0d last %0b",
					$time, word_code, last);
				error_count++;
			end else begin
				oldest_word = expected_words.pop_front();
				if (word_code !== oldest_word.code) begin
					$display("%0t: word_code mismatch: expected %0d, got %0d",
						$time, oldest_word.code, word_code);
					error_count++;
				end
				if (last !== oldest_word.last) begin
					$display("%0t: last mismatch: expected %0b, got %0b",
						$time, oldest_word.last, last);
					error_count++;
				end
			end
		end
	end

	// watchdog: too long without a handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((value_valid && !value_stall) || (word_valid && !word_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_MAX);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// zero, single digits, teens, tens, hundreds, scale edges, the maximum
	task automatic test_directed_values();
		send_value(0);
		send_value(1);
		send_value(9);
		send_value(10);
		send_value(13);
		send_value(19);
		send_value(20);
		send_value(21);
		send_value(99);
		send_value(100);
		send_value(110);
		send_value(999);
		send_value(1000);
		send_value(1001);
		send_value(100000);
		send_value(1000000);
		send_value(1000000000);
		send_value(1010000000);
		send_value(1000000019);
		send_value(2000000000);
		send_value(1999999999);
		send_value(1777777777);
		send_value(VALUE_W'(VALUE_MAX));
	endtask

	// longest spellings back to back with no idling, so the queue fills
	// and the value channel has to stall
	task automatic test_steady_long_words();
		steady_mode = 1'b1;
		for (int i = 0; i < NUM_STEADY; i++)
			send_value(join_groups(1, full_group(), full_group(), full_group()));
		drain_words();
		steady_mode = 1'b0;
	endtask

	// bursts separated by a full drain of the word channel
	task automatic test_drain_between_bursts();
		for (int b = 0; b < 2; b++) begin
			for (int i = 0; i < NUM_BURST; i++)
				send_value(random_value());
			drain_words();
		end
	endtask

	task automatic test_random_values();
		for (int i = 0; i < NUM_RANDOM; i++)
			send_value(random_value());
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_values();
		test_steady_long_words();
		test_drain_between_bursts();
		test_random_values();

		// let the last words out, then keep watching for stray tokens
		drain_words();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d integers, %0d word tokens checked, longest spelling %0d words",
			requests_sent, words_checked, longest_spell);
		$display("%0d mismatches", error_count);
		if (error_count == 0 && expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
src/n2w_pkg.sv
src/n2w_front.sv
src/n2w_queue.sv
src/n2w_back.sv
src/number_to_word_tokens_unit.sv
tb/testbench.sv
